### hw/rtl/jfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfa_pkg: shared types and constants
// Frame markers, calibration reset values, the sequencer state type and the
// control bundle that the sequencer drives into each axis unit.
// ----------------------------------------------------------------------------
package jfa_pkg;

    localparam int unsigned WIN_KEEP   = 5;
    localparam int unsigned FILL_W     = 3;
    localparam int unsigned DIV_STEPS  = 15;
    localparam int unsigned CNT_W      = 4;

    localparam logic [7:0] FRAME_HEAD    = 8'hFF;
    localparam logic [7:0] FRAME_TAIL    = 8'hFE;
    localparam logic [7:0] CAL_MARGIN    = 8'd8;
    localparam logic [7:0] CAL_MAX_RST   = 8'd192;
    localparam logic [7:0] CAL_MID_RST   = 8'd128;
    localparam logic [7:0] CAL_MIN_RST   = 8'd64;
    localparam logic [7:0] DEAD_ZONE_RST = 8'd10;

    localparam logic [14:0] QUO_POS_MAX = 15'd127;
    localparam logic [14:0] QUO_NEG_MAX = 15'd128;
    localparam logic [7:0]  AXIS_POS_LIM = 8'h7F;
    localparam logic [7:0]  AXIS_NEG_LIM = 8'h80;

    // Register index of the dead zone register.
    localparam logic REG_DEAD_ZONE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic cal;    // latch raw sample and extend calibration
        logic setup;  // load the divider operands
        logic step;   // one restoring division step
    } axis_ctl_t;

endpackage

### hw/rtl/joystick_frame_autocal_axes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_frame_autocal_axes: stick frame parser with axis auto-calibration
// Finds 6-byte frames in a byte stream and gives one calibrated, dead-zoned
// X/Y result per frame.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on rx_byte with in_valid/in_ready; results leave on
// x_axis/y_axis with out_valid/out_ready. A request on either channel is
// taken when valid and ready are both high. The dead zone register sits at
// APB byte address 0 and resets to 10.
// A byte that does not close a frame is taken and in_ready stays high. A
// byte that closes a frame starts the axis work: the divider is loaded,
// then the bit-serial divider runs, shared by nothing else (both axes
// run side by side), then the output register is loaded. The result then
// becomes valid and in_ready returns together with it; no new byte is
// taken while a frame is being worked on.
// The output register holds a result while out_ready is low; the block then
// waits in its final step until the register frees up.
// Reset empties the byte window, restores the calibration to 64/128/192 and
// clears out_valid.
// ----------------------------------------------------------------------------
module joystick_frame_autocal_axes
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [7:0] x_axis,
    output logic signed [7:0] y_axis,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import jfa_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       x_axis_reg;
    logic [7:0]       y_axis_reg;
    logic [7:0]       dead_zone_reg;

    logic             in_fire;
    logic             hit;
    logic [7:0]       raw_x;
    logic [7:0]       raw_y;
    logic             load_out;
    logic signed [7:0] x_val;
    logic signed [7:0] y_val;
    axis_ctl_t        ctl;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign x_axis    = x_axis_reg;
    assign y_axis    = y_axis_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {24'd0, dead_zone_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEAD_ZONE))
        begin
            dead_zone_reg <= pwdata[7:0];
        end
    end

    jfa_window u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_fire),
        .rx_byte (rx_byte),
        .hit     (hit),
        .raw_x   (raw_x),
        .raw_y   (raw_y)
    );

    jfa_axis u_axis_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .raw       (raw_x),
        .dead_zone (dead_zone_reg),
        .value     (x_val)
    );

    jfa_axis u_axis_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .raw       (raw_y),
        .dead_zone (dead_zone_reg),
        .value     (y_val)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ctl            = '0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && hit)
                begin
                    ctl.cal    = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                ctl.setup  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            x_axis_reg <= x_val;
            y_axis_reg <= y_val;
        end
    end

    a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && hit) |=> (state_reg == S_SETUP))
        else $error("frame did not start the axis work");

    a_plain_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !hit) |=> (state_reg == S_IDLE))
        else $error("non-frame byte left the idle state");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

### hw/rtl/jfa_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfa_window: byte window and frame detector
// Keeps the last five received bytes and flags a frame when the oldest byte
// is the head marker and the incoming byte is the tail marker.
// ----------------------------------------------------------------------------
module jfa_window
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] rx_byte,
    output logic       hit,
    output logic [7:0] raw_x,
    output logic [7:0] raw_y
);
    import jfa_pkg::*;

    logic [7:0]        win_reg  [WIN_KEEP];
    logic [7:0]        win_next [WIN_KEEP];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              full;

    assign full  = (fill_reg == FILL_W'(WIN_KEEP));
    assign hit   = full && (win_reg[0] == FRAME_HEAD) && (rx_byte == FRAME_TAIL);
    assign raw_x = win_reg[3];
    assign raw_y = win_reg[4];

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (push)
        begin
            if (!full)
            begin
                win_next[fill_reg] = rx_byte;
                fill_next          = fill_reg + FILL_W'(1);
            end
            else if (hit)
            begin
                for (int i = 0; i < WIN_KEEP; i++)
                begin
                    win_next[i] = 8'd0;
                end
                fill_next = '0;
            end
            else
            begin
                for (int i = 0; i < WIN_KEEP - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[WIN_KEEP-1] = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_KEEP; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            fill_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_KEEP))
        else $error("window fill count out of range");

    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && hit) |=> (fill_reg == '0))
        else $error("window not emptied after a frame");

    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("window fill did not advance");

endmodule

### hw/rtl/jfa_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfa_axis: one axis of calibration and scaling
// Extends the min/mid/max calibration, then scales the sample against the
// half-range with a bit-serial restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module jfa_axis
(
    input  logic                clk,
    input  logic                rst_n,
    input  jfa_pkg::axis_ctl_t  ctl,
    input  logic [7:0]          raw,
    input  logic [7:0]          dead_zone,
    output logic signed [7:0]   value
);
    import jfa_pkg::*;

    logic [7:0]  max_reg;
    logic [7:0]  mid_reg;
    logic [7:0]  min_reg;
    logic [7:0]  max_next;
    logic [7:0]  mid_next;
    logic [7:0]  min_next;
    logic [7:0]  raw_reg;
    logic [7:0]  div_reg;
    logic [7:0]  rem_reg;
    logic [14:0] num_reg;
    logic [14:0] q_reg;
    logic        neg_reg;
    logic        zero_reg;

    logic        ext_up;
    logic        ext_dn;
    logic [7:0]  raw_lo;
    logic [8:0]  raw_hi;
    logic [8:0]  cal_sum;
    logic [8:0]  trial;
    logic [8:0]  trial_sub;
    logic        fits;
    logic        below_dz;

    // Calibration extension from the incoming sample.
    assign raw_lo  = raw - CAL_MARGIN;
    assign raw_hi  = {1'b0, raw} + {1'b0, CAL_MARGIN};
    assign ext_up  = (raw >= CAL_MARGIN) && (raw_lo > max_reg);
    assign ext_dn  = (raw_hi < {1'b0, min_reg});

    always_comb
    begin
        max_next = ext_up ? raw_lo : max_reg;
        min_next = ext_dn ? raw_hi[7:0] : min_reg;
        cal_sum  = {1'b0, max_next} + {1'b0, min_next};
        mid_next = (ext_up || ext_dn) ? cal_sum[8:1] : mid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= CAL_MAX_RST;
            mid_reg <= CAL_MID_RST;
            min_reg <= CAL_MIN_RST;
        end
        else if (ctl.cal)
        begin
            max_reg <= max_next;
            mid_reg <= mid_next;
            min_reg <= min_next;
        end
    end

    // Restoring division step: shift in one numerator bit, subtract if it fits.
    assign trial     = {rem_reg, num_reg[14]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.cal)
        begin
            raw_reg <= raw;
        end
        if (ctl.setup)
        begin
            rem_reg <= 8'd0;
            q_reg   <= 15'd0;
            if ((raw_reg > mid_reg) && (max_reg > mid_reg))
            begin
                num_reg  <= {raw_reg - mid_reg, 7'd0};
                div_reg  <= max_reg - mid_reg;
                neg_reg  <= 1'b0;
                zero_reg <= 1'b0;
            end
            else if ((raw_reg < mid_reg) && (mid_reg > min_reg))
            begin
                num_reg  <= {mid_reg - raw_reg, 7'd0};
                div_reg  <= mid_reg - min_reg;
                neg_reg  <= 1'b1;
                zero_reg <= 1'b0;
            end
            else
            begin
                num_reg  <= 15'd0;
                div_reg  <= 8'd1;
                neg_reg  <= 1'b0;
                zero_reg <= 1'b1;
            end
        end
        else if (ctl.step)
        begin
            rem_reg <= fits ? trial_sub[7:0] : trial[7:0];
            num_reg <= {num_reg[13:0], 1'b0};
            q_reg   <= {q_reg[13:0], fits};
        end
    end

    // Dead zone first, then the clamp.
    assign below_dz = (q_reg < {7'd0, dead_zone});

    always_comb
    begin
        if (zero_reg || below_dz)
        begin
            value = 8'sd0;
        end
        else if (!neg_reg)
        begin
            value = (q_reg > QUO_POS_MAX) ? AXIS_POS_LIM : q_reg[7:0];
        end
        else
        begin
            value = (q_reg > QUO_NEG_MAX) ? AXIS_NEG_LIM : (~q_reg[7:0] + 8'd1);
        end
    end

    a_cal_order: assert property (@(posedge clk) disable iff (!rst_n)
        (min_reg <= mid_reg) && (mid_reg <= max_reg))
        else $error("calibration points out of order");

    a_cal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.cal |=> $stable(max_reg) && $stable(min_reg) && $stable(mid_reg))
        else $error("calibration changed outside a frame");

    a_one_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.cal, ctl.setup, ctl.step}))
        else $error("overlapping axis control");

endmodule
